@@ src/asi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asi_pkg
// Shared types, codes and reset values for the arming safety interlock.
// ----------------------------------------------------------------------------
package asi_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned MaskW    = 16;
  localparam int unsigned FaultW   = 4;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned ActW     = 2;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 24;

  localparam int unsigned ChannelsDef = 8;

  localparam logic [CfgW-1:0] ArmHoldReset    = 16'd1000;
  localparam logic [CfgW-1:0] TickBudgetReset = 16'd100;

  typedef enum logic [ModeW-1:0] {
    MODE_BOOT    = 3'd0,
    MODE_SAFE    = 3'd1,
    MODE_PENDING = 3'd2,
    MODE_ARMED   = 3'd3,
    MODE_LOCKOUT = 3'd4
  } mode_e;

  typedef enum logic [ActW-1:0] {
    ACT_BOOT   = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_HEALTH = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    REG_ARM_HOLD    = 1'b0,
    REG_TICK_BUDGET = 1'b1
  } reg_idx_e;

  localparam logic [FaultW-1:0] FaultNone    = 4'd0;
  localparam logic [FaultW-1:0] FaultEstop   = 4'd1;
  localparam logic [FaultW-1:0] FaultOverrun = 4'd2;

  typedef struct packed {
    mode_e             mode;
    logic [FaultW-1:0] fault;
    logic              edge_seen;
    logic [TimeW-1:0]  pending_start;
    logic [TimeW-1:0]  last_tick;
    logic              tick_seen;
    logic              ticked;
  } state_t;

  typedef struct packed {
    logic [CfgW-1:0] arm_hold;
    logic [CfgW-1:0] tick_budget;
  } cfg_t;

  typedef struct packed {
    logic [MaskW-1:0]  request_mask;
    logic              arm_b;
    logic              arm_a;
    logic              link_ok;
    logic              arm_key;
    logic              estop_closed;
    logic [FaultW-1:0] fault_in;
    logic [TimeW-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic              health_ok;
    logic [MaskW-1:0]  fire_mask;
    logic [FaultW-1:0] fault_out;
    logic [ModeW-1:0]  mode;
  } result_t;

endpackage

@@ src/asi_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asi_cfg
// Configuration register file: arm hold time and tick budget.
// ----------------------------------------------------------------------------
module asi_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [0:0]    cfg_index_i,
  input  logic [asi_pkg::CfgW-1:0] cfg_data_i,
  output asi_pkg::cfg_t cfg_o
);

  asi_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_hold    <= asi_pkg::ArmHoldReset;
      cfg_q.tick_budget <= asi_pkg::TickBudgetReset;
    end else if (cfg_valid_i) begin
      case (asi_pkg::reg_idx_e'(cfg_index_i))
        asi_pkg::REG_ARM_HOLD:    cfg_q.arm_hold    <= cfg_data_i;
        asi_pkg::REG_TICK_BUDGET: cfg_q.tick_budget <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/asi_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asi_step
// Next-state and result logic for one action against the current state.
// ----------------------------------------------------------------------------
module asi_step #(
  parameter int unsigned CHANNELS = asi_pkg::ChannelsDef
) (
  input  asi_pkg::state_t  state_i,
  input  asi_pkg::cfg_t    cfg_i,
  input  asi_pkg::action_e action_i,
  input  asi_pkg::item_t   item_i,
  output asi_pkg::state_t  state_o,
  output asi_pkg::result_t result_o
);

  localparam logic [asi_pkg::MaskW-1:0] ChanMask =
    {asi_pkg::MaskW{1'b1}} >> (asi_pkg::MaskW - CHANNELS);

  logic                     both, hs, witnessed, hold;
  logic [asi_pkg::TimeW-1:0] tick_gap, pend_gap;
  asi_pkg::state_t          s;
  logic [asi_pkg::MaskW-1:0] fire;
  logic                     health;

  assign both      = item_i.arm_a & item_i.arm_b;
  assign hs        = item_i.link_ok & both & item_i.arm_key;
  assign witnessed = item_i.link_ok & ~both;
  assign tick_gap  = item_i.now_ms - state_i.last_tick;
  assign pend_gap  = item_i.now_ms - state_i.pending_start;

  always_comb begin
    s      = state_i;
    fire   = '0;
    health = 1'b0;
    hold   = 1'b0;
    case (action_i)
      asi_pkg::ACT_BOOT: begin
        if (state_i.mode == asi_pkg::MODE_BOOT) begin
          if (item_i.fault_in != asi_pkg::FaultNone) begin
            s.mode  = asi_pkg::MODE_LOCKOUT;
            s.fault = item_i.fault_in;
          end else begin
            s.mode      = asi_pkg::MODE_SAFE;
            s.edge_seen = 1'b0;
          end
        end
      end
      asi_pkg::ACT_TICK: begin
        s.ticked = 1'b1;
        if (state_i.tick_seen && (tick_gap > {16'd0, cfg_i.tick_budget}) &&
            state_i.mode != asi_pkg::MODE_BOOT) begin
          s.mode  = asi_pkg::MODE_LOCKOUT;
          s.fault = asi_pkg::FaultOverrun;
        end
        s.last_tick = item_i.now_ms;
        s.tick_seen = 1'b1;
        if (!item_i.estop_closed) begin
          if (s.mode != asi_pkg::MODE_BOOT) begin
            s.mode  = asi_pkg::MODE_LOCKOUT;
            s.fault = asi_pkg::FaultEstop;
          end
        end else begin
          case (s.mode)
            asi_pkg::MODE_SAFE: begin
              hold = s.edge_seen | witnessed;
              if (witnessed) s.edge_seen = 1'b1;
              if (hold && hs) begin
                s.mode          = asi_pkg::MODE_PENDING;
                s.pending_start = item_i.now_ms;
              end
            end
            asi_pkg::MODE_PENDING: begin
              if (!hs) begin
                s.mode      = asi_pkg::MODE_SAFE;
                s.edge_seen = witnessed;
              end else if (pend_gap >= {16'd0, cfg_i.arm_hold}) begin
                s.mode = asi_pkg::MODE_ARMED;
              end
            end
            asi_pkg::MODE_ARMED: begin
              if (!hs) begin
                s.mode      = asi_pkg::MODE_SAFE;
                s.edge_seen = witnessed;
              end
            end
            asi_pkg::MODE_LOCKOUT: begin
              if (item_i.link_ok && !item_i.arm_a && !item_i.arm_b) begin
                s.mode      = asi_pkg::MODE_SAFE;
                s.edge_seen = 1'b0;
              end
            end
            default: ;
          endcase
        end
        if (s.mode == asi_pkg::MODE_ARMED) fire = item_i.request_mask & ChanMask;
      end
      asi_pkg::ACT_REPORT: begin
        s.mode  = asi_pkg::MODE_LOCKOUT;
        s.fault = item_i.fault_in;
      end
      default: begin
        health   = state_i.ticked;
        s.ticked = 1'b0;
      end
    endcase
  end

  assign state_o            = s;
  assign result_o.mode      = s.mode;
  assign result_o.fault_out = s.fault;
  assign result_o.fire_mask = fire;
  assign result_o.health_ok = health;

endmodule

@@ src/arming_safety_interlock_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arming_safety_interlock_core
// Five-mode arming interlock driven by boot, tick, fault and health actions.
// ----------------------------------------------------------------------------
// usage:
//   s_axis: one action per transaction; tuser carries the action code,
//   tdata the time stamp, fault code, hardware/console flags and request mask.
//   m_axis: exactly one result per action (mode, latched fault, fire mask,
//   health flag), in order.
//   cfg: register writes (0 arm hold time, 1 tick budget), always ready;
//   write only while the block is idle.
//   result path: an accepted action is registered in the input register, then
//   its result in the result register; throughput one action per cycle while
//   m_axis is not stalled, set by the combinational state update.
//   stall: while m_axis is held, the result register keeps its transaction and
//   the input register fills; s_axis_tready_o drops once both are full.
//   reset: mode boot, no fault, timers and tick flags cleared, config
//   registers at their defaults, both channels empty.
// ----------------------------------------------------------------------------
module arming_safety_interlock_core #(
  parameter int unsigned CHANNELS = asi_pkg::ChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // now_ms[31:0], fault_in[35:32], estop_closed[36], arm_key[37], link_ok[38],
  // arm_a[39], arm_b[40], request_mask[56:41], zero[63:57]
  input  logic [asi_pkg::InDataW-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  logic [asi_pkg::ActW-1:0]     s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // mode[2:0], fault_out[6:3], fire_mask[22:7], health_ok[23]
  output logic [asi_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [asi_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned ItemW = $bits(asi_pkg::item_t);

  logic               in_valid_q;
  asi_pkg::item_t     in_item_q;
  asi_pkg::action_e   in_act_q;
  logic               out_valid_q;
  asi_pkg::result_t   out_q;
  asi_pkg::state_t    state_q, state_d;
  asi_pkg::result_t   result_d;
  asi_pkg::cfg_t      cfg;
  logic               advance, in_take;

  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign in_take         = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  asi_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  asi_step #(
    .CHANNELS (CHANNELS)
  ) u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .action_i (in_act_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: asi_pkg::MODE_BOOT, fault: asi_pkg::FaultNone,
                       edge_seen: 1'b0, pending_start: '0, last_tick: '0,
                       tick_seen: 1'b0, ticked: 1'b0};
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= asi_pkg::item_t'(s_axis_tdata_i[ItemW-1:0]);
      in_act_q  <= asi_pkg::action_e'(s_axis_tuser_i);
    end
    if (advance) out_q <= result_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

@@ tb/asi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asi_checker
// Watches the input, result and register channels of the arming interlock.
// Keeps its own copy of the interlock state and settings, works out the result
// of every accepted action and compares it field by field with the results
// that come out, in order.
// ----------------------------------------------------------------------------
module asi_checker #(
  parameter int unsigned CHANNELS = asi_pkg::ChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [asi_pkg::InDataW-1:0]  s_tdata_i,
  input  logic [asi_pkg::ActW-1:0]     s_tuser_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [asi_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [0:0]                   cfg_index_i,
  input  logic [asi_pkg::CfgW-1:0]     cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import asi_pkg::*;

  localparam logic [MaskW-1:0] ChanMask =
    (CHANNELS >= MaskW) ? {MaskW{1'b1}} : MaskW'((1 << CHANNELS) - 1);

  mode_e             st_mode;
  logic [FaultW-1:0] st_fault;
  logic              st_edge;
  logic [TimeW-1:0]  st_pend_start;
  logic [TimeW-1:0]  st_last_tick;
  logic              st_tick_seen;
  logic              st_ticked;
  logic [CfgW-1:0]   hold_ms;
  logic [CfgW-1:0]   budget_ms;

  result_t           awaited_q[$];
  result_t           got;
  result_t           want;
  int unsigned       errs;

  assign fail_count_o = errs;

  function automatic void enter_lockout(logic [FaultW-1:0] code);
    st_mode  = MODE_LOCKOUT;
    st_fault = code;
  endfunction

  function automatic void enter_safe();
    st_mode = MODE_SAFE;
    st_edge = 1'b0;
  endfunction

  function automatic result_t interlock_step(action_e act, item_t it);
    result_t          r;
    logic             both;
    logic             hs;
    logic             witnessed;
    logic             held;
    logic [TimeW-1:0] gap;
    r         = '0;
    both      = it.arm_a & it.arm_b;
    hs        = it.link_ok & both;
    witnessed = it.link_ok & ~both;
    held      = hs & it.arm_key;
    case (act)
      ACT_BOOT: begin
        if (st_mode == MODE_BOOT) begin
          if (it.fault_in != FaultNone) enter_lockout(it.fault_in);
          else enter_safe();
        end
      end
      ACT_TICK: begin
        st_ticked = 1'b1;
        gap = it.now_ms - st_last_tick;
        if (st_tick_seen && gap > TimeW'(budget_ms) && st_mode != MODE_BOOT)
          enter_lockout(FaultOverrun);
        st_last_tick = it.now_ms;
        st_tick_seen = 1'b1;
        if (!it.estop_closed) begin
          if (st_mode != MODE_BOOT) enter_lockout(FaultEstop);
        end else begin
          case (st_mode)
            MODE_SAFE: begin
              if (witnessed) st_edge = 1'b1;
              if (st_edge && held) begin
                st_mode       = MODE_PENDING;
                st_pend_start = it.now_ms;
              end
            end
            MODE_PENDING: begin
              gap = it.now_ms - st_pend_start;
              if (!held) begin
                enter_safe();
                if (witnessed) st_edge = 1'b1;
              end else if (gap >= TimeW'(hold_ms)) begin
                st_mode = MODE_ARMED;
              end
            end
            MODE_ARMED: begin
              if (!held) begin
                enter_safe();
                if (witnessed) st_edge = 1'b1;
              end
            end
            MODE_LOCKOUT: begin
              if (it.link_ok && !it.arm_a && !it.arm_b) enter_safe();
            end
            default: ;
          endcase
        end
        if (st_mode == MODE_ARMED) r.fire_mask = it.request_mask & ChanMask;
      end
      ACT_REPORT: enter_lockout(it.fault_in);
      default: begin
        r.health_ok = st_ticked;
        st_ticked   = 1'b0;
      end
    endcase
    r.mode      = st_mode;
    r.fault_out = st_fault;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_mode       = MODE_BOOT;
      st_fault      = FaultNone;
      st_edge       = 1'b0;
      st_pend_start = '0;
      st_last_tick  = '0;
      st_tick_seen  = 1'b0;
      st_ticked     = 1'b0;
      hold_ms       = ArmHoldReset;
      budget_ms     = TickBudgetReset;
      awaited_q.delete();
      errs          = 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_ARM_HOLD:    hold_ms   = cfg_data_i;
          REG_TICK_BUDGET: budget_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i);
        if (awaited_q.size() == 0) begin
          $error("result transaction with nothing outstanding: %h", m_tdata_i);
          errs++;
        end else begin
          want = awaited_q.pop_front();
          if (got.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, got.mode);
            errs++;
          end
          if (got.fault_out !== want.fault_out) begin
            $error("fault_out: expected %0d, got %0d", want.fault_out, got.fault_out);
            errs++;
          end
          if (got.fire_mask !== want.fire_mask) begin
            $error("fire_mask: expected %h, got %h", want.fire_mask, got.fire_mask);
            errs++;
          end
          if (got.health_ok !== want.health_ok) begin
            $error("health_ok: expected %0d, got %0d", want.health_ok, got.health_ok);
            errs++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        awaited_q.push_back(interlock_step(action_e'(s_tuser_i),
                                           item_t'(s_tdata_i[$bits(item_t)-1:0])));
      pending_o <= awaited_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the arming safety interlock core. A directed run
// walks boot, lockout, the arm handshake and the fault paths; random arming
// sessions with random content and bursts of noise follow under several
// register settings and three back-pressure profiles. Results are checked by
// asi_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import asi_pkg::*;

  localparam int unsigned StuckLimit = 5000;
  localparam int unsigned PerSetting = 215;

  logic                  clk_i = 1'b0;
  logic                  rst_n;
  logic                  s_valid;
  logic                  s_ready;
  logic [InDataW-1:0]    s_data;
  action_e               s_user;
  logic                  m_valid;
  logic                  m_ready;
  logic [OutDataW-1:0]   m_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  reg_idx_e              cfg_index;
  logic [CfgW-1:0]       cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;

  int unsigned           gap_pct;
  int unsigned           stall_pct;
  int unsigned           sent;
  int unsigned           stuck_cycles;
  logic [TimeW-1:0]      now_tb;
  logic [CfgW-1:0]       hold_v;
  logic [CfgW-1:0]       budget_v;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  arming_safety_interlock_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  asi_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tuser_i    (s_user),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [FaultW-1:0] rand_fault();
    return FaultW'($urandom_range(15));
  endfunction

  function automatic logic [MaskW-1:0] rand_mask();
    return MaskW'($urandom_range(16'hFFFF));
  endfunction

  task automatic send(action_e act, item_t it);
    while ($urandom_range(99) < gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= {{(InDataW - $bits(item_t)){1'b0}}, it};
    do @(posedge clk_i); while (!s_ready);
    sent++;
  endtask

  task automatic tick(logic [TimeW-1:0] dt, logic estop, logic key, logic link,
                      logic fa, logic fb);
    item_t it;
    now_tb          = now_tb + dt;
    it.now_ms       = now_tb;
    it.fault_in     = rand_fault();
    it.estop_closed = estop;
    it.arm_key      = key;
    it.link_ok      = link;
    it.arm_a        = fa;
    it.arm_b        = fb;
    it.request_mask = rand_mask();
    send(ACT_TICK, it);
  endtask

  task automatic cmd(action_e act, logic [FaultW-1:0] fin);
    item_t it;
    it.now_ms       = $urandom();
    it.fault_in     = fin;
    it.estop_closed = coin();
    it.arm_key      = coin();
    it.link_ok      = coin();
    it.arm_a        = coin();
    it.arm_b        = coin();
    it.request_mask = rand_mask();
    send(act, it);
  endtask

  function automatic logic [TimeW-1:0] step_dt();
    if (budget_v == 0) return '0;
    return TimeW'($urandom_range(int'(budget_v), int'(budget_v) / 2));
  endfunction

  task automatic maybe_query();
    if ($urandom_range(99) < 6) cmd(ACT_HEALTH, rand_fault());
  endtask

  task automatic noise_burst();
    item_t   it;
    action_e act;
    repeat ($urandom_range(6, 1)) begin
      act             = action_e'($urandom_range(3));
      it.now_ms       = $urandom();
      it.fault_in     = rand_fault();
      it.estop_closed = coin();
      it.arm_key      = coin();
      it.link_ok      = coin();
      it.arm_a        = coin();
      it.arm_b        = coin();
      it.request_mask = rand_mask();
      if (act == ACT_TICK) now_tb = it.now_ms;
      send(act, it);
    end
  endtask

  // clear any lockout, witness the released flags, hold the handshake up to the arm hold time (at most 40 ticks)
  task automatic arm_session();
    logic [TimeW-1:0] dt;
    logic [TimeW-1:0] span;
    int unsigned      steps;
    span  = '0;
    steps = 0;
    tick(step_dt(), 1'b1, coin(), 1'b1, 1'b0, 1'b0);
    maybe_query();
    tick(step_dt(), 1'b1, coin(), 1'b1, 1'b0, 1'b0);
    tick(step_dt(), 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    do begin
      dt   = step_dt();
      span = span + dt;
      maybe_query();
      if ($urandom_range(99) < 5)
        tick(dt, $urandom_range(99) < 80, coin(), coin(), coin(), coin());
      else
        tick(dt, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      steps++;
    end while (span < TimeW'(hold_v) && steps < 40);
    repeat ($urandom_range(6, 1)) begin
      maybe_query();
      tick(step_dt(), 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    end
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(3))
          0: tick(step_dt(), 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
          1: tick(step_dt(), 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
          2: tick(step_dt(), 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
          default: tick(step_dt(), 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        endcase
      end
      1: tick(step_dt(), 1'b0, coin(), coin(), coin(), coin());
      2: cmd(ACT_REPORT, rand_fault());
      3: tick(TimeW'(budget_v) + 1 + $urandom_range(500), 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      4: cmd(ACT_HEALTH, rand_fault());
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic apply_setting(int unsigned idx);
    case (idx)
      1: begin hold_v = 16'd0;     budget_v = 16'd0;     end
      2: begin hold_v = 16'hFFFF;  budget_v = 16'hFFFF;  end
      3: begin
        hold_v   = CfgW'($urandom_range(600, 1));
        budget_v = CfgW'($urandom_range(300, 30));
      end
      4: begin hold_v = 16'hFFFF;  budget_v = 16'd0;     end
      default: begin
        hold_v   = CfgW'($urandom_range(2000));
        budget_v = CfgW'($urandom_range(500, 1));
      end
    endcase
    wait_idle();
    write_reg(REG_ARM_HOLD, hold_v);
    write_reg(REG_TICK_BUDGET, budget_v);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned quota;
    rst_n        <= 1'b0;
    s_valid      <= 1'b0;
    s_data       <= '0;
    s_user       <= ACT_BOOT;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_ARM_HOLD;
    cfg_data     <= '0;
    stuck_cycles <= 0;
    gap_pct      = 9;
    stall_pct    = 52;
    sent         = 0;
    hold_v       = ArmHoldReset;
    budget_v     = TickBudgetReset;
    now_tb       = 32'hFFFF_FFF0;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // boot mode: e-stop and overrun have no effect, a report still locks out
    cmd(ACT_HEALTH, FaultNone);
    tick(0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(5000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    cmd(ACT_HEALTH, FaultNone);
    cmd(ACT_REPORT, FaultNone);
    cmd(ACT_BOOT, FaultNone);
    // lockout clears only with link up and both flags low
    tick(100, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    tick(100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    // handshake without a witnessed release must not arm; after a release it arms, then drop, overrun and e-stop follow
    tick(100, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    tick(100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    tick(100, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    repeat (10) tick(100, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    tick(100, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    tick(101, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    tick(100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    tick(100, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    cmd(ACT_REPORT, 4'hF);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin gap_pct = 9;  stall_pct = 52; end
        1: begin gap_pct = 52; stall_pct = 9;  end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        if (ph != 0 || sub != 0) apply_setting(2 * ph + sub);
        quota = sent + PerSetting;
        while (sent < quota) begin
          if ($urandom_range(99) < 80) arm_session();
          else noise_burst();
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
